@@ rtl/sgsl_pkg.sv @@
// Shared types and constants for the two-axis step gate with soft limits.
package sgsl_pkg;

  localparam int MASK_WIDTH      = 2;
  localparam int INTERVAL_WIDTH  = 32;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 32;

  localparam logic [INTERVAL_WIDTH-1:0] STEP_INTERVAL_RESET = INTERVAL_WIDTH'(1000);

  typedef enum logic [0:0] {
    FUNC_TICK   = 1'b0,
    FUNC_PRESET = 1'b1
  } func_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_STEP_INTERVAL     = 3'd0,
    CFG_LEFT_MAX_LIMIT    = 3'd1,
    CFG_LEFT_MIN_LIMIT    = 3'd2,
    CFG_RIGHT_MAX_LIMIT   = 3'd3,
    CFG_RIGHT_MIN_LIMIT   = 3'd4,
    CFG_DIRECTION_INVERT  = 3'd5,
    CFG_SOFT_LIMIT_ENABLE = 3'd6
  } cfg_reg_t;

endpackage

@@ rtl/sgsl_in_if.sv @@
// Input channel interface: tick and preset transactions.
interface sgsl_in_if #(parameter int POSITION_WIDTH = 24);
  import sgsl_pkg::*;

  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [MASK_WIDTH-1:0]            step_mask;
  logic [MASK_WIDTH-1:0]            dir_mask;
  logic signed [POSITION_WIDTH-1:0] left_preset;
  logic signed [POSITION_WIDTH-1:0] right_preset;

  modport source (
    output valid, func, step_mask, dir_mask, left_preset, right_preset,
    input  ready
  );

  modport sink (
    input  valid, func, step_mask, dir_mask, left_preset, right_preset,
    output ready
  );
endinterface

@@ rtl/sgsl_out_if.sv @@
// Result channel interface: step pulses, direction pins and positions.
interface sgsl_out_if #(parameter int POSITION_WIDTH = 24);
  import sgsl_pkg::*;

  logic                             valid;
  logic                             ready;
  logic [MASK_WIDTH-1:0]            step_pulse;
  logic [MASK_WIDTH-1:0]            dir_pins;
  logic                             step_taken;
  logic signed [POSITION_WIDTH-1:0] left_position;
  logic signed [POSITION_WIDTH-1:0] right_position;

  modport source (
    output valid, step_pulse, dir_pins, step_taken, left_position, right_position,
    input  ready
  );

  modport sink (
    input  valid, step_pulse, dir_pins, step_taken, left_position, right_position,
    output ready
  );
endinterface

@@ rtl/sgsl_cfg_if.sv @@
// Configuration write channel interface.
interface sgsl_cfg_if;
  import sgsl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

@@ rtl/sgsl_axis.sv @@
// One axis: unit step with optional soft-limit check.
module sgsl_axis #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic                             request,
  input  logic                             down,
  input  logic                             limit_en,
  input  logic signed [POSITION_WIDTH-1:0] count,
  input  logic signed [POSITION_WIDTH-1:0] min_limit,
  input  logic signed [POSITION_WIDTH-1:0] max_limit,
  output logic                             pulse,
  output logic signed [POSITION_WIDTH-1:0] count_nxt
);

  logic signed [POSITION_WIDTH:0] count_ext;
  logic signed [POSITION_WIDTH:0] next_ext;
  logic signed [POSITION_WIDTH:0] min_ext;
  logic signed [POSITION_WIDTH:0] max_ext;
  logic                           blocked;

  // exact new position, one bit wider so limits see no wrap
  assign count_ext = {count[POSITION_WIDTH-1], count};
  assign min_ext   = {min_limit[POSITION_WIDTH-1], min_limit};
  assign max_ext   = {max_limit[POSITION_WIDTH-1], max_limit};
  assign next_ext  = down ? (count_ext - (POSITION_WIDTH+1)'(1))
                          : (count_ext + (POSITION_WIDTH+1)'(1));

  assign blocked   = limit_en && ((next_ext > max_ext) || (next_ext < min_ext));
  assign pulse     = request && !blocked;
  assign count_nxt = pulse ? next_ext[POSITION_WIDTH-1:0] : count;

endmodule

@@ rtl/two_axis_step_gate_soft_limits_core.sv @@
// Two-axis step gate with soft limits: top level.
// Registered path from input transaction to result: input register, then result register.
// Throughput: one transaction per cycle while out_ch accepts results; the combinational timer/limit update allows this.
// Output register lets a new input be taken while a result waits for out_ch.ready.
// Reset (rst_n low, synchronous): pipeline empty, registers to defaults,
// positions at the largest positive value, timer and direction latch zero.
module two_axis_step_gate_soft_limits_core #(
  parameter int POSITION_WIDTH = 24,
  parameter int TIMER_WIDTH    = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  sgsl_cfg_if.sink     cfg_ch,
  sgsl_in_if.sink      in_ch,
  sgsl_out_if.source   out_ch
);
  import sgsl_pkg::*;

  localparam logic signed [POSITION_WIDTH-1:0] POS_MAX = {1'b0, {(POSITION_WIDTH-1){1'b1}}};
  localparam logic signed [POSITION_WIDTH-1:0] POS_MIN = {1'b1, {(POSITION_WIDTH-1){1'b0}}};

  // configuration
  logic [INTERVAL_WIDTH-1:0]        step_interval_r;
  logic signed [POSITION_WIDTH-1:0] left_max_r;
  logic signed [POSITION_WIDTH-1:0] left_min_r;
  logic signed [POSITION_WIDTH-1:0] right_max_r;
  logic signed [POSITION_WIDTH-1:0] right_min_r;
  logic [MASK_WIDTH-1:0]            dir_invert_r;
  logic                             limit_en_r;

  // block state
  logic signed [POSITION_WIDTH-1:0] left_count_r, left_count_nxt;
  logic signed [POSITION_WIDTH-1:0] right_count_r, right_count_nxt;
  logic [TIMER_WIDTH-1:0]           elapsed_r, elapsed_nxt;
  logic [MASK_WIDTH-1:0]            dir_latch_r, dir_latch_nxt;

  // input stage
  logic                             s1_valid_r;
  func_t                            s1_func_r;
  logic [MASK_WIDTH-1:0]            s1_step_mask_r;
  logic [MASK_WIDTH-1:0]            s1_dir_mask_r;
  logic signed [POSITION_WIDTH-1:0] s1_left_preset_r;
  logic signed [POSITION_WIDTH-1:0] s1_right_preset_r;

  // result stage
  logic                             out_valid_r;
  logic [MASK_WIDTH-1:0]            out_step_pulse_r;
  logic [MASK_WIDTH-1:0]            out_dir_pins_r;
  logic                             out_step_taken_r;
  logic signed [POSITION_WIDTH-1:0] out_left_r;
  logic signed [POSITION_WIDTH-1:0] out_right_r;

  logic                             in_fire;
  logic                             advance;
  logic [TIMER_WIDTH-1:0]           elapsed_inc;
  logic                             gate_open;
  logic                             left_pulse, right_pulse;
  logic signed [POSITION_WIDTH-1:0] left_step_cnt, right_step_cnt;
  logic [MASK_WIDTH-1:0]            step_pulse_nxt;
  logic                             step_taken_nxt;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.step_pulse     = out_step_pulse_r;
  assign out_ch.dir_pins       = out_dir_pins_r;
  assign out_ch.step_taken     = out_step_taken_r;
  assign out_ch.left_position  = out_left_r;
  assign out_ch.right_position = out_right_r;

  // saturating timer and timing gate
  assign elapsed_inc = (elapsed_r == {TIMER_WIDTH{1'b1}}) ? elapsed_r
                                                          : elapsed_r + TIMER_WIDTH'(1);
  assign gate_open   = (s1_func_r == FUNC_TICK) && (s1_step_mask_r != '0) &&
                       (INTERVAL_WIDTH'(elapsed_inc) > step_interval_r);

  sgsl_axis #(.POSITION_WIDTH(POSITION_WIDTH)) u_left_axis (
    .request   (gate_open && s1_step_mask_r[0]),
    .down      (s1_dir_mask_r[0]),
    .limit_en  (limit_en_r),
    .count     (left_count_r),
    .min_limit (left_min_r),
    .max_limit (left_max_r),
    .pulse     (left_pulse),
    .count_nxt (left_step_cnt)
  );

  sgsl_axis #(.POSITION_WIDTH(POSITION_WIDTH)) u_right_axis (
    .request   (gate_open && s1_step_mask_r[1]),
    .down      (s1_dir_mask_r[1]),
    .limit_en  (limit_en_r),
    .count     (right_count_r),
    .min_limit (right_min_r),
    .max_limit (right_max_r),
    .pulse     (right_pulse),
    .count_nxt (right_step_cnt)
  );

  always_comb begin
    unique case (s1_func_r)
      FUNC_PRESET: begin
        left_count_nxt  = s1_left_preset_r;
        right_count_nxt = s1_right_preset_r;
        elapsed_nxt     = elapsed_r;
        dir_latch_nxt   = dir_latch_r;
        step_pulse_nxt  = '0;
        step_taken_nxt  = 1'b0;
      end
      FUNC_TICK: begin
        left_count_nxt  = left_step_cnt;
        right_count_nxt = right_step_cnt;
        elapsed_nxt     = gate_open ? '0 : elapsed_inc;
        dir_latch_nxt   = gate_open ? (s1_dir_mask_r ^ dir_invert_r) : dir_latch_r;
        step_pulse_nxt  = {right_pulse, left_pulse};
        step_taken_nxt  = gate_open;
      end
      default: begin
        left_count_nxt  = left_count_r;
        right_count_nxt = right_count_r;
        elapsed_nxt     = elapsed_r;
        dir_latch_nxt   = dir_latch_r;
        step_pulse_nxt  = '0;
        step_taken_nxt  = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_interval_r <= STEP_INTERVAL_RESET;
      left_max_r      <= POS_MAX;
      left_min_r      <= POS_MIN;
      right_max_r     <= POS_MAX;
      right_min_r     <= POS_MIN;
      dir_invert_r    <= '0;
      limit_en_r      <= 1'b1;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_STEP_INTERVAL:     step_interval_r <= cfg_ch.data[INTERVAL_WIDTH-1:0];
        CFG_LEFT_MAX_LIMIT:    left_max_r      <= cfg_ch.data[POSITION_WIDTH-1:0];
        CFG_LEFT_MIN_LIMIT:    left_min_r      <= cfg_ch.data[POSITION_WIDTH-1:0];
        CFG_RIGHT_MAX_LIMIT:   right_max_r     <= cfg_ch.data[POSITION_WIDTH-1:0];
        CFG_RIGHT_MIN_LIMIT:   right_min_r     <= cfg_ch.data[POSITION_WIDTH-1:0];
        CFG_DIRECTION_INVERT:  dir_invert_r    <= cfg_ch.data[MASK_WIDTH-1:0];
        CFG_SOFT_LIMIT_ENABLE: limit_en_r      <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // block state, updated as a transaction leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_count_r  <= POS_MAX;
      right_count_r <= POS_MAX;
      elapsed_r     <= '0;
      dir_latch_r   <= '0;
    end else if (advance) begin
      left_count_r  <= left_count_nxt;
      right_count_r <= right_count_nxt;
      elapsed_r     <= elapsed_nxt;
      dir_latch_r   <= dir_latch_nxt;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r         <= func_t'(in_ch.func);
      s1_step_mask_r    <= in_ch.step_mask;
      s1_dir_mask_r     <= in_ch.dir_mask;
      s1_left_preset_r  <= in_ch.left_preset;
      s1_right_preset_r <= in_ch.right_preset;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_step_pulse_r <= step_pulse_nxt;
      out_dir_pins_r   <= dir_latch_nxt;
      out_step_taken_r <= step_taken_nxt;
      out_left_r       <= left_count_nxt;
      out_right_r      <= right_count_nxt;
    end
  end

endmodule
